// File: design/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HeapBytesDef   = 4096;
    localparam int HeaderBytesDef = 8;

    // fixed field widths
    localparam int ReqW      = 13;
    localparam int FreeAddrW = 12;
    localparam int StatusW   = 2;
    localparam int OutAddrW  = 12;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [StatusW-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FIT    = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_CHK,
        ST_A_TAIL,
        ST_F_FIRST,
        ST_F_CHK,
        ST_F_NEXT
    } t_state;

endpackage : ffha_pkg
`default_nettype wire

// File: design/ffha_hdr_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one header slot per byte offset, one write and one read port,
// read data in the cycle after the address. Slot 0 lives in a register so that
// reset can put the whole heap into one free block at once.
// ----------------------------------------------------------------------------
module ffha_hdr_mem
    import ffha_pkg::*;
#(
    parameter int DEPTH = HeapBytesDef,
    localparam int AW = $clog2(DEPTH),
    localparam int SW = $clog2(DEPTH + 1),
    localparam int DW = SW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_q;
    logic          r_rd_zero;
    logic [DW-1:0] r_head0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr != '0)) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0   <= {1'b0, SW'(DEPTH)};
            r_rd_zero <= 1'b0;
        end else begin
            r_rd_zero <= (i_rd_addr == '0);
            if (i_wr_en && (i_wr_addr == '0)) begin
                r_head0 <= i_wr_data;
            end
        end
    end

    assign o_rd_data = r_rd_zero ? r_head0 : r_q;

endmodule : ffha_hdr_mem
`default_nettype wire

// File: design/first_fit_heap_allocator.sv
`default_nettype none
// An allocate reads block headers until the first free fit or the heap end, then
// writes the used tail header on a fit; a free reads them until its block or the end.
// The walk reads one header per cycle from the single read port of the header store,
// so at most HEAP_BYTES / HEADER_BYTES are read. A first-block free needs no walk.
// One request at a time: busy stays high until the result is out; the receiver
// cannot stall. Synchronous reset leaves the heap as one free block, no sweep.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit boundary-tag allocator over a byte heap. Walks block headers from
// offset 0, carves used blocks from the tail of the first free fit, and merges
// freed blocks with free neighbors.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HeapBytesDef,
    parameter int HEADER_BYTES = HeaderBytesDef
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_req_type,
    input  wire logic [ReqW-1:0]      i_alloc_size,
    input  wire logic [FreeAddrW-1:0] i_free_addr,
    output logic                      o_done,
    output logic      [StatusW-1:0]   o_status,
    output logic      [OutAddrW-1:0]  o_addr
);

    localparam int PW = $clog2(HEAP_BYTES);
    localparam int SW = $clog2(HEAP_BYTES + 1);
    localparam int DW = SW + 1;
    localparam int CW = ((SW > ReqW) ? SW : ReqW) + 2;

    localparam logic [SW-1:0] HEAP_S = SW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] HDR2_C = CW'(2 * HEADER_BYTES);

    // offset of the block after pos, or the heap end on a broken header
    function automatic logic [SW-1:0] next_blk(input logic [PW-1:0] pos,
                                               input logic [SW-1:0] sz);
        logic [SW:0] room;
        logic [SW:0] sum;
        room = (SW+1)'(HEAP_BYTES) - (SW+1)'(pos);
        sum  = (SW+1)'(pos) + (SW+1)'(sz);
        if ((sz == '0) || ((SW+1)'(sz) > room)) begin
            return HEAP_S;
        end
        return sum[SW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_prev_pos;
    logic               r_prev_used;
    logic [SW-1:0]      r_prev_size;
    logic [PW-1:0]      r_nb;
    logic [SW-1:0]      r_take;
    logic [PW-1:0]      r_base;
    logic [SW-1:0]      r_bsize;
    logic [ReqW-1:0]    r_req;
    logic [FreeAddrW-1:0] r_faddr;
    logic               r_done, n_done;
    logic [StatusW-1:0] r_status, n_status;
    logic [OutAddrW-1:0] r_addr, n_addr;

    logic [PW-1:0]      rd_addr;
    logic [DW-1:0]      rd_data;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic [DW-1:0]      wr_data;

    logic               accept;
    logic               first_free;
    logic               hdr_used;
    logic [SW-1:0]      hdr_size;
    logic [SW-1:0]      nxt;
    logic               at_end;
    logic               fit;
    logic [CW-1:0]      size_c;
    logic [CW-1:0]      take_c;
    logic [CW-1:0]      nb_c;
    logic [CW-1:0]      tail_c;
    logic               hit;
    logic [PW-1:0]      base;
    logic [SW-1:0]      bsize;
    logic [SW-1:0]      bnext;
    logic               bnext_end;
    logic [SW-1:0]      fsize;

    ffha_hdr_mem #(
        .DEPTH (HEAP_BYTES)
    ) u_hdr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_addr   = r_addr;

    // header decode and per-block checks
    always_comb begin
        first_free = (CW'(i_free_addr) == HDR_C);
        hdr_used   = rd_data[SW];
        hdr_size   = rd_data[SW-1:0];
        nxt        = next_blk(r_pos, hdr_size);
        at_end     = (nxt == HEAP_S);
        size_c     = CW'(hdr_size);
        fit        = !hdr_used && (size_c >= HDR2_C) && ((size_c - HDR2_C) >= CW'(r_req));
        take_c     = CW'(r_req) + HDR_C;
        nb_c       = CW'(r_pos) + (size_c - take_c);
        tail_c     = CW'(r_nb) + HDR_C;
        hit        = ((CW'(r_pos) + HDR_C) == CW'(r_faddr));
        base       = r_prev_used ? r_pos : r_prev_pos;
        bsize      = r_prev_used ? hdr_size : (r_prev_size + hdr_size);
        bnext      = next_blk(base, bsize);
        bnext_end  = (bnext == HEAP_S);
        fsize      = hdr_used ? r_bsize : (r_bsize + hdr_size);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_ALLOC) begin
                        n_state = ST_A_CHK;
                    end else if (!first_free) begin
                        n_state = ST_F_FIRST;
                    end
                end
            end
            ST_A_CHK: begin
                if (fit) begin
                    n_state = ST_A_TAIL;
                end else if (at_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_A_TAIL: n_state = ST_IDLE;
            ST_F_FIRST: begin
                n_state = at_end ? ST_IDLE : ST_F_CHK;
            end
            ST_F_CHK: begin
                if (hit) begin
                    n_state = bnext_end ? ST_IDLE : ST_F_NEXT;
                end else if (at_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_F_NEXT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory port and result
    always_comb begin
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = '0;
        n_done   = 1'b0;
        n_status = STAT_OK;
        n_addr   = '0;
        case (r_state)
            ST_IDLE: begin
                // slot 0 is never marked used, so freeing it only answers
                if (accept && (i_req_type == REQ_FREE) && first_free) begin
                    n_done = 1'b1;
                end
            end
            ST_A_CHK: begin
                if (fit) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = {1'b0, SW'(size_c - take_c)};
                end else if (at_end) begin
                    n_done   = 1'b1;
                    n_status = STAT_NO_FIT;
                end else begin
                    rd_addr = nxt[PW-1:0];
                end
            end
            ST_A_TAIL: begin
                wr_en   = 1'b1;
                wr_addr = r_nb;
                wr_data = {1'b1, r_take};
                n_done  = 1'b1;
                n_addr  = tail_c[OutAddrW-1:0];
            end
            ST_F_FIRST, ST_F_CHK: begin
                if ((r_state == ST_F_CHK) && hit) begin
                    if (bnext_end) begin
                        wr_en   = 1'b1;
                        wr_addr = base;
                        wr_data = {1'b0, bsize};
                        n_done  = 1'b1;
                    end else begin
                        rd_addr = bnext[PW-1:0];
                    end
                end else if (at_end) begin
                    n_done   = 1'b1;
                    n_status = STAT_NOT_FOUND;
                end else begin
                    rd_addr = nxt[PW-1:0];
                end
            end
            ST_F_NEXT: begin
                wr_en   = 1'b1;
                wr_addr = r_base;
                wr_data = {1'b0, fsize};
                n_done  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_status <= STAT_OK;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_status <= n_status;
            r_addr   <= n_addr;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pos   <= '0;
                r_req   <= i_alloc_size;
                r_faddr <= i_free_addr;
            end
            ST_A_CHK: begin
                r_pos  <= nxt[PW-1:0];
                r_nb   <= nb_c[PW-1:0];
                r_take <= take_c[SW-1:0];
            end
            ST_F_FIRST, ST_F_CHK: begin
                // advance: the block just read becomes the predecessor
                r_prev_pos  <= r_pos;
                r_prev_used <= hdr_used;
                r_prev_size <= hdr_size;
                r_pos       <= nxt[PW-1:0];
                r_base      <= base;
                r_bsize     <= bsize;
            end
            default: ;
        endcase
    end

endmodule : first_fit_heap_allocator
`default_nettype wire
